@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the moving-average checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is held low.
`define MCVA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("mcva assertion failed");

// Clocked assertion that also holds across reset.
`define MCVA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("mcva assertion failed");

`endif

@@ design/mcva_pkg.sv @@
// ----------------------------------------------------------------------------
// mcva_pkg
// Shared constants, types and register codes for the moving-average block.
// ----------------------------------------------------------------------------
package mcva_pkg;

    localparam int WINDOW    = 20;   // samples per channel window
    localparam int CHANNELS  = 3;    // sensor channels held in the store
    localparam int CH_W      = 2;    // channel field width
    localparam int SMP_W     = 12;   // sample / limit / average width
    localparam int PADDR_W   = 3;    // two 32-bit registers
    localparam int REG_LSB   = 2;    // byte offset bits of paddr

    localparam int POS_W     = $clog2(WINDOW);
    localparam int FILL_W    = $clog2(WINDOW + 1);
    localparam int MAG_W     = $clog2(WINDOW * (2 ** (SMP_W - 1)) + 1);
    localparam int SUM_W     = MAG_W + 1;
    localparam int DEPTH     = CHANNELS * WINDOW;
    localparam int ADDR_W    = $clog2(DEPTH);

    // Exact floor(x / WINDOW) for x < 2**MAG_W: x * RECIP >> DIV_K
    localparam int             DIV_K   = MAG_W + $clog2(WINDOW);
    localparam longint unsigned RECIP  =
        ((longint'(1) << DIV_K) + longint'(WINDOW) - 1) / longint'(WINDOW);
    localparam int             RECIP_W = $clog2(RECIP + 1);
    localparam int             PROD_W  = MAG_W + RECIP_W;

    // Result queue: covers every beat in the pipe plus the waiting ones
    localparam int OUT_DEPTH = 8;
    localparam int FIFO_AW   = $clog2(OUT_DEPTH);
    localparam int OCC_W     = $clog2(OUT_DEPTH + 1);

    localparam logic signed [SMP_W-1:0] LOW_LIMIT_RST  = -12'sd480;
    localparam logic signed [SMP_W-1:0] HIGH_LIMIT_RST = 12'sd960;

    typedef enum logic [PADDR_W-REG_LSB-1:0] {
        REG_LOW_LIMIT  = 1'b0,
        REG_HIGH_LIMIT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic held;
        logic no_data;
    } flags_t;

    function automatic logic chan_ok(input logic [CH_W-1:0] ch);
        chan_ok = int'(ch) < CHANNELS;
    endfunction

endpackage

@@ design/mcva_sample_ram.sv @@
// ----------------------------------------------------------------------------
// mcva_sample_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mcva_sample_ram #(
    parameter int DATA_W  = 12,
    parameter int ENTRIES = 60,
    parameter int AW      = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [ENTRIES];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/mcva_update.sv @@
// ----------------------------------------------------------------------------
// mcva_update
// Per-channel state, sample validation and window sum read-modify-write.
// ----------------------------------------------------------------------------
module mcva_update (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_accept,
    input  logic [mcva_pkg::CH_W-1:0]           in_channel,
    input  logic signed [mcva_pkg::SMP_W-1:0]   in_sample,
    input  logic                                in_failed,
    input  logic signed [mcva_pkg::SMP_W-1:0]   low_limit,
    input  logic signed [mcva_pkg::SMP_W-1:0]   high_limit,
    output logic                                ram_re,
    output logic [mcva_pkg::ADDR_W-1:0]         ram_raddr,
    input  logic [mcva_pkg::SMP_W-1:0]          ram_rdata,
    output logic                                ram_we,
    output logic [mcva_pkg::ADDR_W-1:0]         ram_waddr,
    output logic [mcva_pkg::SMP_W-1:0]          ram_wdata,
    output logic                                out_valid,
    output logic signed [mcva_pkg::SUM_W-1:0]   out_sum,
    output mcva_pkg::flags_t                    out_flags
);

    import mcva_pkg::*;

    // channel state
    logic                     primed_reg [CHANNELS];
    logic [POS_W-1:0]         pos_reg    [CHANNELS];
    logic [FILL_W-1:0]        fill_reg   [CHANNELS];
    logic signed [SMP_W-1:0]  prime_reg  [CHANNELS];
    logic signed [SMP_W-1:0]  last_reg   [CHANNELS];
    logic signed [SUM_W-1:0]  sum_reg    [CHANNELS];

    // update stage (memory data arrives here)
    logic                     b_valid_reg;
    logic [CH_W-1:0]          b_ch_reg;
    logic signed [SMP_W-1:0]  b_smp_reg;
    logic                     b_failed_reg;
    logic [ADDR_W-1:0]        b_addr_reg;
    logic [POS_W-1:0]         b_pos_reg;

    // output stage
    logic                     c_valid_reg;
    logic signed [SUM_W-1:0]  c_sum_reg;
    flags_t                   c_flags_reg;

    logic                     ch_ok;
    logic                     cur_primed;
    logic [FILL_W-1:0]        cur_fill;
    logic signed [SMP_W-1:0]  cur_prime;
    logic signed [SMP_W-1:0]  cur_last;
    logic signed [SUM_W-1:0]  cur_sum;
    logic                     take;
    logic                     priming;
    logic                     do_upd;
    logic signed [SMP_W-1:0]  v;
    logic signed [SMP_W-1:0]  old;
    logic signed [SUM_W-1:0]  sum_next;
    logic [FILL_W-1:0]        fill_next;
    logic [POS_W-1:0]         pos_next;
    flags_t                   flags_next;

    logic                     fwd;
    logic [POS_W-1:0]         rd_pos;

    always_comb begin
        ch_ok      = chan_ok(b_ch_reg);
        cur_primed = ch_ok ? primed_reg[b_ch_reg] : 1'b0;
        cur_fill   = ch_ok ? fill_reg[b_ch_reg]   : '0;
        cur_prime  = ch_ok ? prime_reg[b_ch_reg]  : '0;
        cur_last   = ch_ok ? last_reg[b_ch_reg]   : '0;
        cur_sum    = ch_ok ? sum_reg[b_ch_reg]    : '0;

        take    = !b_failed_reg && (b_smp_reg >= low_limit) && (b_smp_reg <= high_limit);
        priming = take && !cur_primed;
        do_upd  = ch_ok && (take || cur_primed);
        v       = take ? b_smp_reg : cur_last;

        // slots not yet written stand for the priming sample
        old = (cur_fill < FILL_W'(WINDOW)) ? cur_prime : $signed(ram_rdata);

        if (priming) begin
            sum_next = SUM_W'(b_smp_reg) * SUM_W'(WINDOW);
        end else begin
            sum_next = cur_sum - SUM_W'(old) + SUM_W'(v);
        end

        if (priming) begin
            fill_next = FILL_W'(1);
        end else if (cur_fill < FILL_W'(WINDOW)) begin
            fill_next = cur_fill + FILL_W'(1);
        end else begin
            fill_next = cur_fill;
        end

        pos_next = (b_pos_reg == POS_W'(WINDOW - 1)) ? '0 : b_pos_reg + POS_W'(1);

        flags_next.held    = ch_ok && !take && cur_primed;
        flags_next.no_data = !do_upd;
    end

    // Ring position forwarded from the beat in the update stage, so a
    // same-channel beat right behind it reads the right slot.
    always_comb begin
        fwd = b_valid_reg && do_upd && (b_ch_reg == in_channel);
        if (fwd) begin
            rd_pos = pos_next;
        end else if (chan_ok(in_channel)) begin
            rd_pos = pos_reg[in_channel];
        end else begin
            rd_pos = '0;
        end
    end

    assign ram_re    = in_accept;
    assign ram_raddr = ADDR_W'(int'(in_channel) * WINDOW) + ADDR_W'(rd_pos);
    assign ram_we    = b_valid_reg && do_upd;
    assign ram_waddr = b_addr_reg;
    assign ram_wdata = v;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                primed_reg[i] <= 1'b0;
                pos_reg[i]    <= '0;
                fill_reg[i]   <= '0;
                prime_reg[i]  <= '0;
                last_reg[i]   <= '0;
                sum_reg[i]    <= '0;
            end
        end else begin
            b_valid_reg <= in_accept;
            c_valid_reg <= b_valid_reg;
            if (b_valid_reg && do_upd) begin
                primed_reg[b_ch_reg] <= 1'b1;
                pos_reg[b_ch_reg]    <= pos_next;
                fill_reg[b_ch_reg]   <= fill_next;
                last_reg[b_ch_reg]   <= v;
                sum_reg[b_ch_reg]    <= sum_next;
                if (priming) begin
                    prime_reg[b_ch_reg] <= b_smp_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            b_ch_reg     <= in_channel;
            b_smp_reg    <= in_sample;
            b_failed_reg <= in_failed;
            b_addr_reg   <= ram_raddr;
            b_pos_reg    <= rd_pos;
        end
        c_sum_reg   <= do_upd ? sum_next : '0;
        c_flags_reg <= flags_next;
    end

    assign out_valid = c_valid_reg;
    assign out_sum   = c_sum_reg;
    assign out_flags = c_flags_reg;

endmodule

@@ design/mcva_div.sv @@
// ----------------------------------------------------------------------------
// mcva_div
// Window sum divided by WINDOW, truncated toward zero, by reciprocal multiply.
// ----------------------------------------------------------------------------
module mcva_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  logic signed [mcva_pkg::SUM_W-1:0]   in_sum,
    input  mcva_pkg::flags_t                    in_flags,
    output logic                                out_valid,
    output logic signed [mcva_pkg::SMP_W-1:0]   out_avg,
    output mcva_pkg::flags_t                    out_flags
);

    import mcva_pkg::*;

    logic               d_valid_reg;
    logic               d_neg_reg;
    logic [MAG_W-1:0]   d_mag_reg;
    flags_t             d_flags_reg;

    logic               e_valid_reg;
    logic               e_neg_reg;
    logic [PROD_W-1:0]  e_prod_reg;
    flags_t             e_flags_reg;

    logic [MAG_W-1:0]   mag_next;
    logic [PROD_W-1:0]  prod_next;
    logic [SMP_W-1:0]   quo;
    logic [SMP_W-1:0]   quo_neg;

    assign mag_next  = in_sum[SUM_W-1] ? MAG_W'(-in_sum) : MAG_W'(in_sum);
    assign prod_next = PROD_W'(d_mag_reg) * PROD_W'(RECIP);
    assign quo       = e_prod_reg[DIV_K +: SMP_W];
    assign quo_neg   = ~quo + SMP_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else begin
            d_valid_reg <= in_valid;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        d_neg_reg   <= in_sum[SUM_W-1];
        d_mag_reg   <= mag_next;
        d_flags_reg <= in_flags;
        e_neg_reg   <= d_neg_reg;
        e_prod_reg  <= prod_next;
        e_flags_reg <= d_flags_reg;
    end

    assign out_valid = e_valid_reg;
    assign out_avg   = e_neg_reg ? $signed(quo_neg) : $signed(quo);
    assign out_flags = e_flags_reg;

endmodule

@@ design/multichannel_validated_moving_average.sv @@
// ----------------------------------------------------------------------------
// multichannel_validated_moving_average
// Per-channel moving average of validated temperature readings.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+----------------------------------
//  s_       | in        | s_valid / s_ready  | channel, sample, read_failed
//  m_       | out       | m_valid / m_ready  | average, held, no_data
//  APB      | in        | psel/penable/pready| 0x0 low_limit, 0x4 high_limit
//
//  One beat accepted per cycle while s_ready is high, any mix of channels;
//  results leave in acceptance order. Throughput is set by the single write
//  port of the sample RAM (one read-modify-write per beat; ring position
//  forwarded between beats). Reset is synchronous; the sample RAM needs no
//  clearing pass. m_ready low backs results into an 8-entry queue; s_ready
//  drops only once the beats in flight plus those queued fill it.
// ----------------------------------------------------------------------------
module multichannel_validated_moving_average (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mcva_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // readings in
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [mcva_pkg::CH_W-1:0]           s_channel,
    input  logic signed [mcva_pkg::SMP_W-1:0]   s_sample,
    input  logic                                s_read_failed,
    // averages out
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [mcva_pkg::SMP_W-1:0]   m_average,
    output logic                                m_held,
    output logic                                m_no_data
);

    import mcva_pkg::*;

    // ---------------- configuration registers ----------------
    logic signed [SMP_W-1:0] low_limit_reg;
    logic signed [SMP_W-1:0] high_limit_reg;
    logic                    cfg_wr;
    reg_idx_t                cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:REG_LSB]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_limit_reg  <= LOW_LIMIT_RST;
            high_limit_reg <= HIGH_LIMIT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_LOW_LIMIT: begin
                    low_limit_reg <= $signed(pwdata[SMP_W-1:0]);
                end
                REG_HIGH_LIMIT: begin
                    high_limit_reg <= $signed(pwdata[SMP_W-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // limits read back sign-extended
    always_comb begin
        case (cfg_idx)
            REG_LOW_LIMIT:  prdata = 32'(low_limit_reg);
            REG_HIGH_LIMIT: prdata = 32'(high_limit_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- input acceptance ----------------
    // occ_reg counts beats accepted and not yet delivered; the queue below
    // is deep enough to hold all of them, so the pipe never stalls.
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             s_acc;
    logic             m_pop;

    assign s_ready  = occ_reg < OCC_W'(OUT_DEPTH);
    assign s_acc    = s_valid && s_ready;
    assign m_pop    = m_valid && m_ready;
    assign occ_next = occ_reg + OCC_W'(s_acc) - OCC_W'(m_pop);

    // ---------------- sample RAM + update ----------------
    logic                    ram_re;
    logic [ADDR_W-1:0]       ram_raddr;
    logic [SMP_W-1:0]        ram_rdata;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [SMP_W-1:0]        ram_wdata;

    logic                    upd_valid;
    logic signed [SUM_W-1:0] upd_sum;
    flags_t                  upd_flags;

    mcva_sample_ram #(
        .DATA_W  (SMP_W),
        .ENTRIES (DEPTH),
        .AW      (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mcva_update u_update (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (s_acc),
        .in_channel (s_channel),
        .in_sample  (s_sample),
        .in_failed  (s_read_failed),
        .low_limit  (low_limit_reg),
        .high_limit (high_limit_reg),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .out_valid  (upd_valid),
        .out_sum    (upd_sum),
        .out_flags  (upd_flags)
    );

    // ---------------- divide by window ----------------
    logic                    div_valid;
    logic signed [SMP_W-1:0] div_avg;
    flags_t                  div_flags;

    mcva_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (upd_valid),
        .in_sum    (upd_sum),
        .in_flags  (upd_flags),
        .out_valid (div_valid),
        .out_avg   (div_avg),
        .out_flags (div_flags)
    );

    // ---------------- result queue ----------------
    logic signed [SMP_W-1:0] q_avg_reg   [OUT_DEPTH];
    flags_t                  q_flags_reg [OUT_DEPTH];
    logic [FIFO_AW-1:0]      wr_ptr_reg;
    logic [FIFO_AW-1:0]      rd_ptr_reg;
    logic [OCC_W-1:0]        q_cnt_reg;
    logic [FIFO_AW-1:0]      wr_ptr_next;
    logic [FIFO_AW-1:0]      rd_ptr_next;

    assign wr_ptr_next = (wr_ptr_reg == FIFO_AW'(OUT_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + FIFO_AW'(1);
    assign rd_ptr_next = (rd_ptr_reg == FIFO_AW'(OUT_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + FIFO_AW'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            q_cnt_reg  <= '0;
        end else begin
            occ_reg   <= occ_next;
            q_cnt_reg <= q_cnt_reg + OCC_W'(div_valid) - OCC_W'(m_pop);
            if (div_valid) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (m_pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_valid) begin
            q_avg_reg[wr_ptr_reg]   <= div_avg;
            q_flags_reg[wr_ptr_reg] <= div_flags;
        end
    end

    assign m_valid   = q_cnt_reg != '0;
    assign m_average = q_avg_reg[rd_ptr_reg];
    assign m_held    = q_flags_reg[rd_ptr_reg].held;
    assign m_no_data = q_flags_reg[rd_ptr_reg].no_data;

endmodule

@@ design/mcva_checker.sv @@
// ----------------------------------------------------------------------------
// mcva_checker
// Port-level checks on results and configuration read-back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcva_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic                                pready,
    input  logic [mcva_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                         pwdata,
    input  logic [31:0]                         prdata,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [mcva_pkg::SMP_W-1:0]   m_average,
    input  logic                                m_held,
    input  logic                                m_no_data
);

    import mcva_pkg::*;

    // nothing pending once reset has been applied
    `MCVA_ASSERT_ALWAYS(a_out_idle_after_reset, aclk, !aresetn |=> !m_valid)

    // an empty-channel result carries a zero mean and is never a held one
    `MCVA_ASSERT(a_no_data_clean, aclk, aresetn, m_valid && m_no_data |-> m_average == '0 && !m_held)

    // a stalled result beat holds
    `MCVA_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_average) && $stable(m_held) && $stable(m_no_data))

    // low limit reads back what was just written
    `MCVA_ASSERT(a_low_readback, aclk, aresetn, psel && penable && pwrite && pready && paddr[REG_LSB] == 1'b0 |=> !(psel && !pwrite && paddr[REG_LSB] == 1'b0) || prdata[SMP_W-1:0] == $past(pwdata[SMP_W-1:0]))

endmodule

bind multichannel_validated_moving_average mcva_checker u_mcva_checker (.*);

@@ tb/multichannel_validated_moving_average_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_validated_moving_average_tb
// Checks the per-channel moving average beat by beat. Readings go in over a
// valid/ready channel in bursts. Limits are set over APB, only while the block
// is idle. A scoreboard class keeps its own copy of every channel's window
// and predicts each result beat. Result beats are taken under a stall
// pattern, with one long hold-off that backs the block up to its input.
// ----------------------------------------------------------------------------
module multichannel_validated_moving_average_tb;

    import mcva_pkg::*;

    localparam int RESULT_LATENCY = 5;                   // acceptance to result
    localparam int SETTLE_CYCLES  = 2 * RESULT_LATENCY;
    localparam int HOLD_CYCLES    = 150;                 // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;                // quiet cycles before giving up
    localparam int CH_MAX         = (1 << CH_W) - 1;

    typedef struct {
        logic signed [SMP_W-1:0] average;
        logic                    held;
        logic                    no_data;
    } avg_result_t;

    // ------------------------------------------------------------------------
    // Window predictor and store of expected averages
    // ------------------------------------------------------------------------
    class avg_scoreboard;
        logic signed [SMP_W-1:0] low_lim;
        logic signed [SMP_W-1:0] high_lim;
        logic signed [SMP_W-1:0] ring      [CHANNELS][WINDOW];
        logic signed [SMP_W-1:0] first_smp [CHANNELS];
        logic signed [SMP_W-1:0] last_smp  [CHANNELS];
        int unsigned             wr_pos    [CHANNELS];
        int unsigned             fill      [CHANNELS];
        int                      sum_q     [CHANNELS];
        bit                      primed    [CHANNELS];
        avg_result_t             expected_q[$];
        int                      errors;

        function new();
            low_lim  = LOW_LIMIT_RST;
            high_lim = HIGH_LIMIT_RST;
            errors   = 0;
            for (int c = 0; c < CHANNELS; c++) begin
                first_smp[c] = '0;
                last_smp[c]  = '0;
                wr_pos[c]    = 0;
                fill[c]      = 0;
                sum_q[c]     = 0;
                primed[c]    = 1'b0;
            end
        endfunction

        function void set_limit(input reg_idx_t idx, input logic signed [SMP_W-1:0] val);
            if (idx == REG_LOW_LIMIT) begin
                low_lim = val;
            end else begin
                high_lim = val;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Accepted reading in, expected result beat out
        function void note_reading(input logic [CH_W-1:0] ch,
                                   input logic signed [SMP_W-1:0] smp,
                                   input logic failed);
            avg_result_t             r;
            logic signed [SMP_W-1:0] v;
            bit                      ok;
            int                      c;
            int unsigned             pos;
            int                      oldv;
            r.average = '0;
            r.held    = 1'b0;
            r.no_data = 1'b1;
            c = int'(ch);
            // channel beyond the store: ignored, no_data
            if (c >= CHANNELS) begin
                expected_q.push_back(r);
                return;
            end
            // crossed limits reject everything, as the compare falls out
            ok = !failed && smp >= low_lim && smp <= high_lim;
            if (!ok) begin
                // rejected on an empty channel: nothing changes
                if (!primed[c]) begin
                    expected_q.push_back(r);
                    return;
                end
                v      = last_smp[c];
                r.held = 1'b1;
            end else begin
                v = smp;
                if (!primed[c]) begin
                    // first good sample stands in for the whole window
                    primed[c]    = 1'b1;
                    first_smp[c] = v;
                    sum_q[c]     = int'(v) * WINDOW;
                    fill[c]      = 0;
                    wr_pos[c]    = 0;
                end
            end
            pos  = wr_pos[c];
            oldv = (fill[c] < WINDOW) ? int'(first_smp[c]) : int'(ring[c][pos]);
            sum_q[c]     = sum_q[c] - oldv + int'(v);
            ring[c][pos] = v;
            last_smp[c]  = v;
            wr_pos[c]    = (pos + 1 >= WINDOW) ? 0 : pos + 1;
            if (fill[c] < WINDOW) fill[c]++;
            r.no_data = 1'b0;
            r.average = SMP_W'(sum_q[c] / WINDOW);   // int divide truncates toward zero
            expected_q.push_back(r);
        endfunction

        function void check_result(input logic signed [SMP_W-1:0] avg,
                                   input logic held, input logic no_data);
            avg_result_t want;
            if (expected_q.size() == 0) begin
                $error("result beat with no reading outstanding: average %0d", avg);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (avg !== want.average) begin
                $error("average: expected %0d, got %0d", want.average, avg);
                errors++;
            end
            if (held !== want.held) begin
                $error("held: expected %0b, got %0b", want.held, held);
                errors++;
            end
            if (no_data !== want.no_data) begin
                $error("no_data: expected %0b, got %0b", want.no_data, no_data);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals - every block input known from time zero
    // ------------------------------------------------------------------------
    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      psel          = 1'b0;
    logic                      penable       = 1'b0;
    logic                      pwrite        = 1'b0;
    logic [PADDR_W-1:0]        paddr         = '0;
    logic [31:0]               pwdata        = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic [CH_W-1:0]           s_channel     = '0;
    logic signed [SMP_W-1:0]   s_sample      = '0;
    logic                      s_read_failed = 1'b0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic signed [SMP_W-1:0]   m_average;
    logic                      m_held;
    logic                      m_no_data;

    avg_scoreboard sb = new();
    bit            hold_req = 1'b0;     // main asks the receiver for a long hold-off
    int            quiet_cycles = 0;

    multichannel_validated_moving_average dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .s_read_failed (s_read_failed),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_average     (m_average),
        .m_held        (m_held),
        .m_no_data     (m_no_data)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Result side: checker and stall pattern
    // ------------------------------------------------------------------------
    // Values read at the edge are the pre-edge ones: all drive is nonblocking.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_average, m_held, m_no_data);
        end
    end

    // Segments of free flow, light and heavy stalling; a hold-off on request.
    initial begin : result_sink
        int seg_left;
        int ready_pct;
        seg_left  = 0;
        ready_pct = 100;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(8, 64);
                    case ($urandom_range(0, 3))
                        0, 1: ready_pct = 100;
                        2:    ready_pct = 60;
                        default: ready_pct = 20;
                    endcase
                end
                seg_left--;
                m_ready <= ($urandom_range(1, 100) <= ready_pct);
                @(posedge aclk);
            end
        end
    end

    // Watchdog: too long without any beat or APB access ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers - each called just after a rising edge
    // ------------------------------------------------------------------------
    // One reading beat; returns at the edge that accepts it, valid left high
    task automatic send_reading(input logic [CH_W-1:0] ch,
                                input logic signed [SMP_W-1:0] smp,
                                input logic failed);
        s_valid       <= 1'b1;
        s_channel     <= ch;
        s_sample      <= smp;
        s_read_failed <= failed;
        do @(posedge aclk); while (!s_ready);
        sb.note_reading(ch, smp, failed);
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    // Stop offering and wait for every outstanding result, then let the pipe settle
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Setup then access phase; psel drops after so accesses never abut
    task automatic apb_access(input bit wr, input reg_idx_t idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, {REG_LSB{1'b0}}};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_limits(input logic signed [SMP_W-1:0] lo,
                                input logic signed [SMP_W-1:0] hi);
        logic [31:0] rd;
        apb_access(1'b1, REG_LOW_LIMIT, {{(32-SMP_W){lo[SMP_W-1]}}, lo}, rd);
        sb.set_limit(REG_LOW_LIMIT, lo);
        apb_access(1'b1, REG_HIGH_LIMIT, {{(32-SMP_W){hi[SMP_W-1]}}, hi}, rd);
        sb.set_limit(REG_HIGH_LIMIT, hi);
        // read back - only the 12 register bits are compared
        apb_access(1'b0, REG_LOW_LIMIT, '0, rd);
        if (rd[SMP_W-1:0] !== lo) begin
            $error("low_limit readback: expected %0d, got %0d", lo, $signed(rd[SMP_W-1:0]));
            sb.errors++;
        end
        apb_access(1'b0, REG_HIGH_LIMIT, '0, rd);
        if (rd[SMP_W-1:0] !== hi) begin
            $error("high_limit readback: expected %0d, got %0d", hi, $signed(rd[SMP_W-1:0]));
            sb.errors++;
        end
    endtask

    // Mostly in-window readings, with extremes, near misses and raw noise
    function automatic logic signed [SMP_W-1:0] pick_sample(input logic signed [SMP_W-1:0] lo,
                                                            input logic signed [SMP_W-1:0] hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 70 && lo <= hi) begin
            return SMP_W'(int'(lo) + int'($urandom_range(0, int'(hi) - int'(lo))));
        end else if (r < 80) begin
            return r[0] ? 12'sd2047 : -12'sd2048;
        end else if (r < 86) begin
            return r[0] ? lo - 1'b1 : hi + 1'b1;
        end
        return SMP_W'($urandom);
    endfunction

    // One limit setting and a stream of random readings in bursts
    task automatic run_phase(input logic signed [SMP_W-1:0] lo,
                             input logic signed [SMP_W-1:0] hi,
                             input int n_items, input bit with_hold);
        int                burst_left;
        logic [CH_W-1:0]   ch;
        logic              failed;
        drain();
        write_limits(lo, hi);
        burst_left = 0;
        for (int i = 0; i < n_items; i++) begin
            if (with_hold && i == n_items / 3) begin
                // receiver holds off while we keep offering back to back
                hold_req   = 1'b1;
                burst_left = 60;
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
            end
            burst_left--;
            ch     = ($urandom_range(0, 99) < 92) ? CH_W'($urandom_range(0, CHANNELS - 1))
                                                  : CH_W'($urandom_range(CHANNELS, CH_MAX));
            failed = ($urandom_range(0, 99) < 8);
            send_reading(ch, pick_sample(lo, hi), failed);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset limits -480..960
        send_reading(2'd0, 12'sd0, 1'b1);          // failed read on empty channel
        send_reading(2'd0, -12'sd481, 1'b0);       // below limit on empty channel
        send_reading(2'd3, 12'sd100, 1'b0);        // channel out of range
        send_reading(2'd3, -12'sd1, 1'b1);         // out of range, all ones
        send_reading(2'd0, -12'sd480, 1'b0);       // exactly low limit: primes
        send_reading(2'd1, 12'sd960, 1'b0);        // exactly high limit: primes
        idle_sender(3);
        send_reading(2'd0, -12'sd481, 1'b0);       // below: held
        send_reading(2'd1, 12'sd961, 1'b0);        // above: held
        send_reading(2'd0, 12'sd100, 1'b1);        // failed on primed: held
        send_reading(2'd2, 12'sd2047, 1'b0);       // rejected, still empty
        send_reading(2'd2, -12'sd2048, 1'b0);
        send_reading(2'd2, 12'sd1, 1'b0);          // primes at 1
        send_reading(2'd2, 12'sd0, 1'b0);          // 19/20 truncates to 0
        send_reading(2'd0, -12'sd479, 1'b0);       // negative mean truncates toward zero

        // Directed, full-range limits
        drain();
        write_limits(-12'sd2048, 12'sd2047);
        send_reading(2'd1, 12'sd2047, 1'b0);
        send_reading(2'd1, -12'sd2048, 1'b0);
        send_reading(2'd0, 12'sd2047, 1'b0);
        send_reading(2'd3, 12'sd2047, 1'b1);
        send_reading(2'd0, -12'sd2048, 1'b1);      // failed: last sample reused

        // Random phases across settings, extremes and crossed limits included
        run_phase(-12'sd2048, 12'sd2047, 400, 1'b1);
        run_phase(LOW_LIMIT_RST, HIGH_LIMIT_RST, 250, 1'b0);
        run_phase(-12'sd100, 12'sd100, 250, 1'b0);
        run_phase(12'sd500, -12'sd500, 100, 1'b0);      // crossed: all in-range channels held
        run_phase(12'sd300, 12'sd300, 100, 1'b0);       // single accepted value
        run_phase(12'sd2047, 12'sd2047, 80, 1'b0);
        run_phase(-12'sd2048, -12'sd2048, 80, 1'b0);
        run_phase(-12'sd2048, 12'sd2047, 200, 1'b0);
        run_phase(SMP_W'(-int'($urandom_range(0, 1200))), SMP_W'($urandom_range(0, 1200)),
                  120, 1'b0);
        run_phase(SMP_W'($urandom), SMP_W'($urandom), 120, 1'b0);

        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
